### hdl/pph_pkg.sv
// Package for the PPG peak heart-rate block: field widths, register
// reset values, register indexes and the shared constants.
// No dependencies.
package pph_pkg;

   localparam int SAMPLE_W   = 18;
   localparam int COUNT_W    = 4;
   localparam int RATE_W     = 8;
   localparam int PERIOD_W   = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 18;

   // quotient register of the shared divider, sized for the rate numerator
   localparam int NUM_W = 16;

   localparam int WINDOW_MAX_DEF = 256;

   localparam logic [NUM_W-1:0]    RATE_NUMERATOR = NUM_W'(60000);
   localparam logic [SAMPLE_W-1:0] HEIGHT_RESET   = SAMPLE_W'(45000 * 5);
   localparam logic [COUNT_W-1:0]  PEAK_HARD_CAP  = COUNT_W'(15);
   localparam logic [COUNT_W-1:0]  PEAKS_RESET    = COUNT_W'(5);
   localparam logic [PERIOD_W-1:0] PERIOD_RESET   = PERIOD_W'(10);
   localparam logic [RATE_W-1:0]   RATE_MAX       = RATE_W'(255);

   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT_THR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PEAKS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD     = 2'd2;

   typedef logic [SAMPLE_W-1:0]   sample_type;
   typedef logic [COUNT_W-1:0]    count_type;
   typedef logic [RATE_W-1:0]     rate_type;
   typedef logic [PERIOD_W-1:0]   period_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

endpackage

### hdl/pph_if.sv
// Valid/ready channel interfaces for the PPG peak heart-rate block:
// the sample channel and the result channel.
// Depends on pph_pkg.
interface pph_req_if;
   import pph_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample;
   logic       last_in_window;

   modport source (output valid, output sample, output last_in_window, input ready);
   modport sink   (input valid, input sample, input last_in_window, output ready);
endinterface

interface pph_rsp_if;
   import pph_pkg::*;

   logic      valid;
   logic      ready;
   rate_type  heart_rate;
   count_type peak_count;
   logic      rate_valid;

   modport source (output valid, output heart_rate, output peak_count,
                   output rate_valid, input ready);
   modport sink   (input valid, input heart_rate, input peak_count,
                   input rate_valid, output ready);
endinterface

### hdl/ppg_peak_heart_rate.sv
// PPG peak detector and heart-rate estimator, top level.
// Depends on pph_pkg and the channel interfaces in pph_if.
//
// Usage:
//   req_ch carries one optical sample per beat; last_in_window marks the
//   final sample of a window. Peak tracking runs in the accept cycle, so a
//   sample that does not close a window is taken every cycle while no rate
//   computation is pending. The closing sample starts the rate computation
//   on one shared bit-serial restoring divider: first the mean peak
//   spacing, then spacing times sample period, then 60000 over that
//   product. The divisions are skipped when fewer than two peaks were
//   found, and the second one when the divisor is zero. req_ch.ready is
//   low until the result moves to the output register, so the next sample
//   waits for that.
//   The result sits in an output register: while rsp_ch stalls, samples of
//   the next window are still taken, and only the next computation waits.
//   csr_* writes the height threshold (0), max_peaks (1) and
//   sample_period_ms (2); write them only while the block is idle.
//   reset (synchronous) restores the register defaults, clears the window
//   state and drops any pending result.
module ppg_peak_heart_rate #(
   parameter int WINDOW_MAX = pph_pkg::WINDOW_MAX_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   pph_req_if.sink                req_ch,
   pph_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  pph_pkg::csr_idx_type   csr_index,
   input  pph_pkg::csr_data_type  csr_wdata
);
   import pph_pkg::*;

   localparam int IDX_W = $clog2(WINDOW_MAX);
   localparam int DEN_W = IDX_W + PERIOD_W;
   localparam int BIT_W = $clog2(NUM_W);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_MAX - 1);
   localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(NUM_W - 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV1 = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_DIV2 = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   // configuration
   sample_type height_thr_ff;
   count_type  max_peaks_ff;
   period_type period_ff;

   // window state
   sample_type       prev_ff,   prev_in;
   logic [IDX_W-1:0] idx_ff,    idx_in;
   logic             plat_ff,   plat_in;
   sample_type       pval_ff,   pval_in;
   logic [IDX_W-1:0] pstart_ff, pstart_in;
   count_type        peaks_ff,  peaks_in;
   logic [IDX_W-1:0] first_ff,  first_in;
   logic [IDX_W-1:0] lastpk_ff, lastpk_in;

   // sequencer and divider
   logic [2:0]       state_ff, state_in;
   logic [BIT_W-1:0] bit_ff,   bit_in;
   logic [NUM_W-1:0] num_ff,   num_in;
   logic [DEN_W-1:0] rem_ff,   rem_in;
   logic [DEN_W-1:0] den_ff,   den_in;
   rate_type         res_rate_ff,  res_rate_in;
   logic             res_valid_ff, res_valid_in;
   count_type        res_count_ff, res_count_in;

   // output register
   logic      rsp_valid_ff, rsp_valid_in;
   rate_type  rsp_rate_ff,  rsp_rate_in;
   count_type rsp_count_ff, rsp_count_in;
   logic      rsp_ok_ff,    rsp_ok_in;

   logic       req_fire;
   sample_type s;
   logic       end_peak;
   logic       plat_keep;
   logic       start_peak;
   logic       log_ok;
   count_type  peaks_new;
   logic [IDX_W-1:0] first_new;
   logic [IDX_W-1:0] last_new;
   logic [DEN_W:0]   rem_shift;
   logic             q_bit;
   logic [DEN_W-1:0] product;
   logic             out_free;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign s            = req_ch.sample;

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.heart_rate = rsp_rate_ff;
   assign rsp_ch.peak_count = rsp_count_ff;
   assign rsp_ch.rate_valid = rsp_ok_ff;
   assign out_free          = !rsp_valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         height_thr_ff <= HEIGHT_RESET;
         max_peaks_ff  <= PEAKS_RESET;
         period_ff     <= PERIOD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HEIGHT_THR: height_thr_ff <= csr_wdata[SAMPLE_W-1:0];
            CSR_MAX_PEAKS:  max_peaks_ff  <= csr_wdata[COUNT_W-1:0];
            CSR_PERIOD:     period_ff     <= csr_wdata[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   // peak tracking for the sample on req_ch
   always_comb begin
      end_peak   = plat_ff && (s < pval_ff);
      plat_keep  = plat_ff && (s == pval_ff);
      start_peak = !plat_keep && !req_ch.last_in_window && (idx_ff != '0) &&
                   (idx_ff < IDX_LAST) && (s > height_thr_ff) && (s > prev_ff);
      log_ok     = end_peak && (peaks_ff < max_peaks_ff) && (peaks_ff != PEAK_HARD_CAP);
      peaks_new  = peaks_ff;
      first_new  = first_ff;
      last_new   = lastpk_ff;
      if (log_ok) begin
         if (peaks_ff == '0) begin
            first_new = pstart_ff;
         end
         last_new  = pstart_ff;
         peaks_new = peaks_ff + 1'b1;
      end

      prev_in   = prev_ff;
      idx_in    = idx_ff;
      plat_in   = plat_ff;
      pval_in   = pval_ff;
      pstart_in = pstart_ff;
      peaks_in  = peaks_ff;
      first_in  = first_ff;
      lastpk_in = lastpk_ff;
      if (req_fire) begin
         if (req_ch.last_in_window) begin
            // window closes: back to the reset state
            prev_in   = '0;
            idx_in    = '0;
            plat_in   = 1'b0;
            pval_in   = '0;
            pstart_in = '0;
            peaks_in  = '0;
            first_in  = '0;
            lastpk_in = '0;
         end else begin
            prev_in   = s;
            plat_in   = plat_keep || start_peak;
            if (start_peak) begin
               pval_in   = s;
               pstart_in = idx_ff;
            end
            peaks_in  = peaks_new;
            first_in  = first_new;
            lastpk_in = last_new;
            if (idx_ff < IDX_LAST) begin
               idx_in = idx_ff + 1'b1;
            end
         end
      end
   end

   // one restoring division step per cycle
   always_comb begin
      rem_shift = {rem_ff, num_ff[NUM_W-1]};
      q_bit     = (rem_shift >= {1'b0, den_ff});
      product   = DEN_W'(num_ff[IDX_W-1:0]) * DEN_W'(period_ff);
   end

   always_comb begin
      state_in     = state_ff;
      bit_in       = bit_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      res_rate_in  = res_rate_ff;
      res_valid_in = res_valid_ff;
      res_count_in = res_count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_rate_in  = rsp_rate_ff;
      rsp_count_in = rsp_count_ff;
      rsp_ok_in    = rsp_ok_ff;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff) inside
         ST_IDLE: begin
            if (req_fire && req_ch.last_in_window) begin
               res_count_in = peaks_new;
               res_rate_in  = '0;
               res_valid_in = 1'b0;
               bit_in       = '0;
               rem_in       = '0;
               num_in       = NUM_W'(last_new - first_new);
               den_in       = DEN_W'(peaks_new - 1'b1);
               state_in     = (peaks_new < COUNT_W'(2)) ? ST_DONE : ST_DIV1;
            end
         end
         ST_DIV1, ST_DIV2: begin
            // remainder stays below the divisor, so the top bit drops
            rem_in = q_bit ? DEN_W'(rem_shift - {1'b0, den_ff}) : rem_shift[DEN_W-1:0];
            num_in = {num_ff[NUM_W-2:0], q_bit};
            bit_in = bit_ff + 1'b1;
            if (bit_ff == BIT_LAST) begin
               state_in = (state_ff == ST_DIV1) ? ST_MUL : ST_DONE;
               if (state_ff == ST_DIV2) begin
                  res_valid_in = 1'b1;
                  res_rate_in  = (num_in > NUM_W'(RATE_MAX)) ? RATE_MAX
                                                              : num_in[RATE_W-1:0];
               end
            end
         end
         ST_MUL: begin
            // spacing quotient sits in num_ff
            den_in   = product;
            rem_in   = '0;
            bit_in   = '0;
            num_in   = RATE_NUMERATOR;
            state_in = (product == '0) ? ST_DONE : ST_DIV2;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_rate_in  = res_rate_ff;
               rsp_count_in = res_count_ff;
               rsp_ok_in    = res_valid_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         idx_ff       <= '0;
         plat_ff      <= 1'b0;
         pval_ff      <= '0;
         pstart_ff    <= '0;
         peaks_ff     <= '0;
         first_ff     <= '0;
         lastpk_ff    <= '0;
         state_ff     <= ST_IDLE;
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prev_ff      <= prev_in;
         idx_ff       <= idx_in;
         plat_ff      <= plat_in;
         pval_ff      <= pval_in;
         pstart_ff    <= pstart_in;
         peaks_ff     <= peaks_in;
         first_ff     <= first_in;
         lastpk_ff    <= lastpk_in;
         state_ff     <= state_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      den_ff       <= den_in;
      res_rate_ff  <= res_rate_in;
      res_valid_ff <= res_valid_in;
      res_count_ff <= res_count_in;
      rsp_rate_ff  <= rsp_rate_in;
      rsp_count_ff <= rsp_count_in;
      rsp_ok_ff    <= rsp_ok_in;
   end

   a_valid_needs_two: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ok_ff) |-> (rsp_count_ff >= COUNT_W'(2)))
      else $error("rate marked valid with fewer than two peaks");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> (rsp_rate_ff == '0))
      else $error("invalid rate is not zero");

   a_window_clear: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_ch.last_in_window) |=>
         (idx_ff == '0 && peaks_ff == '0 && !plat_ff))
      else $error("window state not cleared after closing sample");

   a_peak_order: assert property (@(posedge clock) disable iff (reset)
      (peaks_ff != '0) |-> (lastpk_ff >= first_ff))
      else $error("last peak index below first peak index");

endmodule

### tb/sv/ppg_peak_heart_rate_checker.sv
`timescale 1ns / 1ps
// Checker for ppg_peak_heart_rate: follows every sample beat, tracks peaks per window
// and compares each window report with the block's result beats.
// Depends on pph_pkg.
module ppg_peak_heart_rate_checker #(
   parameter int WINDOW_MAX = pph_pkg::WINDOW_MAX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  pph_pkg::sample_type   req_sample,
   input  logic                  req_last,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  pph_pkg::rate_type     rsp_heart_rate,
   input  pph_pkg::count_type    rsp_peak_count,
   input  logic                  rsp_rate_valid,
   input  logic                  csr_we,
   input  pph_pkg::csr_idx_type  csr_index,
   input  pph_pkg::csr_data_type csr_wdata,
   output int                    fail_count,
   output int                    open_reports
);
   import pph_pkg::*;

   typedef struct packed {
      rate_type  heart_rate;
      count_type peak_count;
      logic      rate_valid;
   } window_report_type;

   window_report_type report_q[$];

   sample_type cfg_height_thr;
   count_type  cfg_max_peaks;
   period_type cfg_period;

   sample_type prev_sample;
   sample_type plat_value;
   logic [7:0] win_index;
   logic [7:0] plat_start;
   logic [7:0] first_peak;
   logic [7:0] last_peak;
   logic       plat_on;
   count_type  peaks;

   function automatic void clear_window();
      prev_sample = '0;
      plat_value  = '0;
      win_index   = '0;
      plat_start  = '0;
      first_peak  = '0;
      last_peak   = '0;
      plat_on     = 1'b0;
      peaks       = '0;
   endfunction

   function automatic void take_sample(sample_type s, logic last);
      logic [7:0]        idx;
      window_report_type rep;
      int unsigned       span;
      int unsigned       spacing;
      int unsigned       divisor;
      int unsigned       rate;
      idx = win_index;
      // a lower sample closes the plateau as a peak, a higher one just drops it
      if (plat_on) begin
         if (s < plat_value) begin
            if (peaks < cfg_max_peaks && peaks < PEAK_HARD_CAP) begin
               if (peaks == 0) first_peak = plat_start;
               last_peak = plat_start;
               peaks = peaks + 1'b1;
            end
            plat_on = 1'b0;
         end else if (s > plat_value) begin
            plat_on = 1'b0;
         end
      end
      if (!plat_on && !last && idx >= 1 && int'(idx) < WINDOW_MAX - 1 &&
          s > cfg_height_thr && s > prev_sample) begin
         plat_on    = 1'b1;
         plat_value = s;
         plat_start = idx;
      end
      prev_sample = s;
      if (!last) begin
         // hold the index at the top once the window runs long
         if (int'(idx) < WINDOW_MAX - 1) win_index = idx + 1'b1;
      end else begin
         rep = '0;
         rep.peak_count = peaks;
         if (peaks >= 2) begin
            span    = last_peak - first_peak;
            spacing = span / (peaks - 1);
            divisor = spacing * cfg_period;
            if (divisor != 0) begin
               rate = RATE_NUMERATOR / divisor;
               if (rate > RATE_MAX) rate = RATE_MAX;
               rep.heart_rate = rate_type'(rate);
               rep.rate_valid = 1'b1;
            end
         end
         report_q.push_back(rep);
         clear_window();
      end
   endfunction

   function automatic void note_failure(string what, window_report_type want,
                                        window_report_type got);
      if (fail_count < 10)
         $display("%s: expected rate %0d count %0d valid %0d, got rate %0d count %0d valid %0d",
                  what, want.heart_rate, want.peak_count, want.rate_valid,
                  got.heart_rate, got.peak_count, got.rate_valid);
      fail_count++;
   endfunction

   always @(posedge clock) begin : track
      window_report_type want;
      window_report_type got;
      if (reset) begin
         cfg_height_thr = HEIGHT_RESET;
         cfg_max_peaks  = PEAKS_RESET;
         cfg_period     = PERIOD_RESET;
         clear_window();
         report_q.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_HEIGHT_THR: cfg_height_thr = csr_wdata[SAMPLE_W-1:0];
               CSR_MAX_PEAKS:  cfg_max_peaks  = csr_wdata[COUNT_W-1:0];
               CSR_PERIOD:     cfg_period     = csr_wdata[PERIOD_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_heart_rate, rsp_peak_count, rsp_rate_valid};
            if (report_q.size() == 0) begin
               note_failure("result beat with no window closed", '0, got);
            end else begin
               want = report_q.pop_front();
               if (got.heart_rate !== want.heart_rate || got.peak_count !== want.peak_count ||
                   got.rate_valid !== want.rate_valid)
                  note_failure("window report mismatch", want, got);
            end
         end
         if (req_valid && req_ready) take_sample(req_sample, req_last);
      end
      open_reports = report_q.size();
   end

endmodule

### tb/sv/ppg_peak_heart_rate_tb.sv
`timescale 1ns / 1ps
// Testbench top for ppg_peak_heart_rate: drives sample windows and register settings,
// throttles the result side and gives the verdict.
// Depends on pph_pkg, pph_if, the block and ppg_peak_heart_rate_checker.
module ppg_peak_heart_rate_tb;
   import pph_pkg::*;

   localparam int WINDOW_MAX    = WINDOW_MAX_DEF;
   localparam int ITEM_TARGET   = 1850;
   localparam int PHASE_ITEMS   = 170;
   localparam int SETTLE_CYCLES = 64;
   localparam int HOLD_CYCLES   = 400;
   localparam int GAP_MAX       = 5;
   localparam int LONG_WINDOW   = 300;

   localparam sample_type  SAMPLE_MAX = '1;
   localparam csr_idx_type CSR_SPARE  = 2'd3;

   typedef enum int {SHAPE_PULSE, SHAPE_NOISE, SHAPE_STEPS} shape_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         csr_we;
   csr_idx_type  csr_index;
   csr_data_type csr_wdata;

   int         fail_count;
   int         open_reports;
   int         req_gap_max;
   int         rsp_gap_max;
   bit         squeeze_req;
   int         sent_items;
   sample_type cur_min;
   sample_type window_q[$];

   pph_req_if req_ch ();
   pph_rsp_if rsp_ch ();

   ppg_peak_heart_rate #(.WINDOW_MAX(WINDOW_MAX)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ppg_peak_heart_rate_checker #(.WINDOW_MAX(WINDOW_MAX)) report_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .req_ready      (req_ch.ready),
      .req_sample     (req_ch.sample),
      .req_last       (req_ch.last_in_window),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_heart_rate (rsp_ch.heart_rate),
      .rsp_peak_count (rsp_ch.peak_count),
      .rsp_rate_valid (rsp_ch.rate_valid),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .open_reports   (open_reports)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic send_beat(sample_type s, logic last);
      int n;
      n = $urandom_range(0, req_gap_max);
      if (n > 0) begin
         req_ch.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.sample         <= s;
      req_ch.last_in_window <= last;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_window();
      foreach (window_q[i]) send_beat(window_q[i], i == window_q.size() - 1);
      sent_items += window_q.size();
   endtask

   task automatic build_window(int len, shape_type shape);
      sample_type base;
      sample_type peak;
      sample_type v;
      window_q.delete();
      case (shape)
         SHAPE_NOISE: repeat (len) window_q.push_back(sample_type'($urandom));
         SHAPE_STEPS: begin
            v = sample_type'($urandom);
            repeat (len) begin
               if ($urandom_range(0, 1)) v = sample_type'($urandom);
               window_q.push_back(v);
            end
         end
         default: begin
            // pulse train: baseline, rise, plateau, sometimes a higher step, then a drop
            while (window_q.size() < len) begin
               base = (cur_min == 0) ? '0 : sample_type'($urandom_range(0, cur_min));
               repeat ($urandom_range(1, 4)) window_q.push_back(base);
               if (cur_min == SAMPLE_MAX) peak = sample_type'($urandom);
               else peak = sample_type'($urandom_range(cur_min + 1, SAMPLE_MAX));
               repeat ($urandom_range(1, 4)) window_q.push_back(peak);
               if ($urandom_range(0, 7) == 0 && peak != SAMPLE_MAX) begin
                  peak = sample_type'($urandom_range(peak + 1, SAMPLE_MAX));
                  repeat ($urandom_range(1, 2)) window_q.push_back(peak);
               end
               window_q.push_back((peak == 0) ? '0 : sample_type'($urandom_range(0, peak - 1)));
            end
            while (window_q.size() > len) void'(window_q.pop_back());
         end
      endcase
   endtask

   task automatic write_csr(csr_idx_type idx, csr_data_type data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic apply_settings(sample_type mh, count_type mp, period_type per);
      csr_data_type data;
      write_csr(CSR_HEIGHT_THR, mh);
      // junk in the unused upper bits must be dropped
      data = csr_data_type'($urandom);
      data[COUNT_W-1:0] = mp;
      write_csr(CSR_MAX_PEAKS, data);
      data = csr_data_type'($urandom);
      data[PERIOD_W-1:0] = per;
      write_csr(CSR_PERIOD, data);
      csr_we  <= 1'b0;
      cur_min = mh;
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (open_reports != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int         len;
      int         phase;
      int         phase_start;
      int         r;
      shape_type  shape;
      sample_type mh;
      count_type  mp;
      period_type per;
      reset                 <= 1'b1;
      req_ch.valid          <= 1'b0;
      req_ch.sample         <= '0;
      req_ch.last_in_window <= 1'b0;
      csr_we                <= 1'b0;
      csr_index             <= CSR_HEIGHT_THR;
      csr_wdata             <= '0;
      squeeze_req = 1'b0;
      sent_items  = 0;
      cur_min     = HEIGHT_RESET;
      req_gap_max = 1;
      rsp_gap_max = GAP_MAX;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single-sample window
      window_q = '{SAMPLE_MAX};
      send_window();
      // plateau peak, peak at full scale, plateau cut by a higher sample, closing max
      window_q = '{'0, 18'd230000, 18'd230000, 18'd229000, SAMPLE_MAX, 18'd100,
                   18'd240000, 18'd250000, 18'd250000, '0, SAMPLE_MAX};
      send_window();
      // plateau still open when the window closes
      window_q = '{'0, 18'd240000, 18'd240000};
      send_window();
      // high first sample ignored, closing sample ends the plateau
      window_q = '{18'd250000, '0, 18'd240000, 18'd200000};
      send_window();

      sent_items = 0;
      phase = 0;
      while (sent_items < ITEM_TARGET) begin
         wait_idle();
         case (phase)
            0: begin mh = HEIGHT_RESET; mp = PEAKS_RESET; per = PERIOD_RESET; end
            1: begin mh = '0; mp = 4'd15; per = 8'd1; end
            2: begin mh = SAMPLE_MAX; mp = 4'd2; per = 8'd255; end
            3: begin mh = 18'd100000; mp = 4'd2; per = 8'd255; end
            4: begin mh = 18'd150000; mp = 4'd15; per = 8'd0; end
            5: begin mh = 18'd200000; mp = 4'd0; per = 8'd10; end
            6: begin mh = 18'd200000; mp = 4'd1; per = 8'd10; end
            default: begin
               mh  = sample_type'($urandom);
               mp  = ($urandom_range(0, 7) == 0) ? count_type'($urandom_range(0, 1))
                                                 : count_type'($urandom_range(2, 15));
               per = ($urandom_range(0, 9) == 0) ? '0 : period_type'($urandom_range(1, 255));
            end
         endcase
         if (phase == 2) write_csr(CSR_SPARE, csr_data_type'($urandom));
         apply_settings(mh, mp, per);
         req_gap_max = (phase % 3 == 1) ? 0 : GAP_MAX;
         rsp_gap_max = (phase % 4 == 2) ? 0 : GAP_MAX;
         if (phase == 3) squeeze_req = 1'b1;
         phase_start = sent_items;
         if (phase == 4 || phase == 8) begin
            build_window((phase == 4) ? LONG_WINDOW : WINDOW_MAX + 1, SHAPE_PULSE);
            send_window();
         end
         while (sent_items - phase_start < PHASE_ITEMS) begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 40);
            r = $urandom_range(0, 9);
            if (r <= 6) shape = SHAPE_PULSE;
            else if (r == 7) shape = SHAPE_NOISE;
            else shape = SHAPE_STEPS;
            build_window(len, shape);
            send_window();
         end
         phase++;
      end

      wait_idle();
      if (fail_count == 0 && open_reports == 0) begin
         $display("[ppg_peak_heart_rate] OK");
      end else begin
         $display("[ppg_peak_heart_rate] ERROR");
      end
      $finish;
   end

   initial begin : result_side
      int n;
      bit squeeze_done;
      squeeze_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      rsp_ch.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (squeeze_req && !squeeze_done) begin
            // hold off long enough for the block to back up into the sample side
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            squeeze_done = 1'b1;
            rsp_ch.ready <= 1'b1;
         end else if (rsp_ch.valid && rsp_ch.ready) begin
            n = $urandom_range(0, rsp_gap_max);
            if (n > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (n) @(posedge clock);
               rsp_ch.ready <= 1'b1;
            end
         end
      end
   end

   initial begin : watchdog
      #2_000_000;
      $display("[ppg_peak_heart_rate] ERROR");
      $finish;
   end

endmodule
